[src/cps_pkg.sv]
// Shared types, constants and codes of the process scheduler.
package cps_pkg;

	localparam int MAX_PROCS = 16;
	localparam int TIME_BITS = 16;
	localparam int SLOT_W    = $clog2(MAX_PROCS);
	localparam int CNT_W     = SLOT_W + 1;

	localparam logic [CNT_W-1:0]     IDLE_SLOT = CNT_W'(MAX_PROCS);
	localparam logic [CNT_W-1:0]     MAX_CNT   = CNT_W'(MAX_PROCS);
	localparam logic [TIME_BITS-1:0] TMAX      = '1;

	localparam logic [1:0] POL_FCFS = 2'd0;
	localparam logic [1:0] POL_SJF  = 2'd1;
	localparam logic [1:0] POL_SRTF = 2'd2;
	localparam logic [1:0] POL_RR   = 2'd3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] REG_POLICY  = 2'd0;
	localparam logic [1:0] REG_QUANTUM = 2'd1;
	localparam logic [1:0] REG_COUNT   = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  slot;
		logic [15:0] arrival_time;
		logic [15:0] burst_time;
	} cps_in_t;

	typedef struct packed {
		logic        busy_res;
		logic [3:0]  running_slot;
		logic        dispatched;
		logic        first_run;
		logic [15:0] response_time;
		logic        completed;
		logic [15:0] turnaround_time;
		logic [15:0] waiting_time;
		logic        all_done;
		logic [15:0] current_tick;
	} cps_out_t;

	typedef struct packed {
		logic accept_load;
		logic accept_tick;
		logic start;
		logic scan;
		logic decide;
		logic pop;
		logic run;
		logic fin;
	} cps_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_tick;
		logic can_accept;
		logic n_zero;
		logic scan_last;
		logic need_pop;
		logic pop_done;
	} cps_stat_t;

endpackage

[src/cps_ctrl.sv]
// Sequencing state machine of the process scheduler.
module cps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  cps_pkg::cps_stat_t stat,
	output cps_pkg::cps_cmd_t  cmd,
	output logic              in_stall
);
	import cps_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_START  = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_POP    = 3'd4;
	localparam logic [2:0] S_RUN    = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0] state_q, state_d;
	logic       accept;

	assign accept   = (state_q == S_IDLE) && stat.can_accept && stat.in_valid;
	assign in_stall = !((state_q == S_IDLE) && stat.can_accept);

	always_comb begin
		cmd             = '0;
		cmd.accept_load = accept && !stat.in_tick;
		cmd.accept_tick = accept && stat.in_tick;
		cmd.start       = (state_q == S_START);
		cmd.scan        = (state_q == S_SCAN);
		cmd.decide      = (state_q == S_DECIDE);
		cmd.pop         = (state_q == S_POP);
		cmd.run         = (state_q == S_RUN);
		cmd.fin         = (state_q == S_FIN);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = stat.in_tick ? S_START : S_FIN;
			end
			S_START:  state_d = stat.n_zero ? S_DECIDE : S_SCAN;
			S_SCAN: begin
				if (stat.scan_last) state_d = S_DECIDE;
			end
			S_DECIDE: state_d = stat.need_pop ? S_POP : S_RUN;
			S_POP: begin
				if (stat.pop_done) state_d = S_RUN;
			end
			S_RUN:    state_d = S_FIN;
			S_FIN:    state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

[src/cps_datapath.sv]
// Process table, ready queue, selection logic and result registers.
module cps_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  cps_pkg::cps_cmd_t  cmd,
	output cps_pkg::cps_stat_t stat,
	input  logic               in_valid,
	input  cps_pkg::cps_in_t   in_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               out_stall,
	output logic               out_valid,
	output cps_pkg::cps_out_t  out_data
);
	import cps_pkg::*;

	logic [1:0]       policy_q;
	logic [7:0]       quantum_q;
	logic [4:0]       count_q;

	logic [TIME_BITS-1:0] arr_mem   [MAX_PROCS];
	logic [TIME_BITS-1:0] burst_mem [MAX_PROCS];
	logic [TIME_BITS-1:0] rem_mem   [MAX_PROCS];
	logic [SLOT_W-1:0]    fifo_mem  [MAX_PROCS];

	logic [MAX_PROCS-1:0] ready_q, done_q, started_q, remnz_q;
	logic [TIME_BITS-1:0] time_q;
	logic [CNT_W-1:0]     cur_slot_q, w_cur_q, prev_q;
	logic [7:0]           slice_q;
	logic [SLOT_W-1:0]    head_q;
	logic [CNT_W-1:0]     fcnt_q;

	logic [SLOT_W-1:0]    scan_idx_q;
	logic [CNT_W-1:0]     best_arr_q, best_rem_q, best_first_q;
	logic [TIME_BITS-1:0] best_arr_key_q, best_rem_key_q;
	logic                 pop_mode_q;
	logic                 tick_q;
	cps_out_t             res_q;
	logic                 out_valid_q;
	cps_out_t             out_q;

	logic [CNT_W-1:0]     n;
	logic [7:0]           slice_len;
	logic [SLOT_W-1:0]    rd_addr;
	logic [TIME_BITS-1:0] rd_arr, rd_burst, rd_rem, new_rem;
	logic                 arrives, scan_run, push_ok;
	logic [SLOT_W-1:0]    fifo_tail;
	logic [CNT_W-1:0]     head_slot, popped;
	logic                 head_ok, pop_found;
	logic                 cur_ok;
	logic [TIME_BITS-1:0] resp, fin_t, tat, wait_t;
	logic [MAX_PROCS-1:0] used_mask;
	logic                 all_done;
	logic                 cur_idle;
	cps_out_t             run_res, fin_res;

	function automatic logic runnable(input logic [CNT_W-1:0] s, input logic [CNT_W-1:0] cnt,
		input logic [MAX_PROCS-1:0] rdy, input logic [MAX_PROCS-1:0] dn);
		logic ok;
		ok = 1'b0;
		if (s < cnt) ok = rdy[s[SLOT_W-1:0]] && !dn[s[SLOT_W-1:0]];
		return ok;
	endfunction

	assign n         = (count_q > MAX_CNT) ? MAX_CNT : count_q;
	assign slice_len = (quantum_q == 8'd0) ? 8'd1 : quantum_q;
	assign cur_idle  = (w_cur_q == IDLE_SLOT);

	assign rd_addr  = cmd.scan ? scan_idx_q : w_cur_q[SLOT_W-1:0];
	assign rd_arr   = arr_mem[rd_addr];
	assign rd_burst = burst_mem[rd_addr];
	assign rd_rem   = rem_mem[rd_addr];
	assign new_rem  = rd_rem - 1'b1;

	assign arrives  = (rd_arr == time_q) && !ready_q[rd_addr] && !done_q[rd_addr];
	assign scan_run = (ready_q[rd_addr] || arrives) && !done_q[rd_addr];
	assign push_ok  = (fcnt_q < MAX_CNT);
	assign fifo_tail = head_q + fcnt_q[SLOT_W-1:0];

	assign head_slot = {1'b0, fifo_mem[head_q]};
	assign head_ok   = runnable(head_slot, n, ready_q, done_q);
	assign pop_found = (fcnt_q != '0) && head_ok;
	assign popped    = pop_found ? head_slot : IDLE_SLOT;
	assign cur_ok    = (cur_slot_q != IDLE_SLOT) && runnable(cur_slot_q, n, ready_q, done_q);

	// Metrics of the running slot; the differences are clamped at zero and the finish time saturates.
	assign resp   = (time_q >= rd_arr) ? time_q - rd_arr : '0;
	assign fin_t  = (time_q != TMAX) ? time_q + 1'b1 : time_q;
	assign tat    = (fin_t >= rd_arr) ? fin_t - rd_arr : '0;
	assign wait_t = (tat > rd_burst) ? tat - rd_burst : '0;

	always_comb begin
		for (int i = 0; i < MAX_PROCS; i++) used_mask[i] = (CNT_W'(i) < n);
	end
	assign all_done = ~|(remnz_q & used_mask);

	// Result of the run step, assembled before it is registered.
	always_comb begin
		run_res = '0;
		if (!cur_idle) begin
			run_res.busy_res     = 1'b1;
			run_res.running_slot = rd_addr;
			run_res.dispatched   = (w_cur_q != prev_q);
			if (!started_q[rd_addr]) begin
				run_res.first_run     = 1'b1;
				run_res.response_time = resp;
			end
			if (new_rem == '0) begin
				run_res.completed       = 1'b1;
				run_res.turnaround_time = tat;
				run_res.waiting_time    = wait_t;
			end
		end
	end

	always_comb begin
		fin_res              = res_q;
		fin_res.all_done     = all_done;
		fin_res.current_tick = time_q;
	end

	always_comb begin
		stat            = '0;
		stat.in_valid   = in_valid;
		stat.in_tick    = (in_data.opcode == OP_TICK);
		stat.can_accept = !out_valid_q || !out_stall;
		stat.n_zero     = (n == '0);
		stat.scan_last  = ({1'b0, scan_idx_q} == n - 1'b1);
		stat.need_pop   = (policy_q == POL_RR) && (cur_idle || slice_q == 8'd0);
		stat.pop_done   = (fcnt_q == '0) || head_ok;
	end

	// Control state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= POL_FCFS;
			quantum_q   <= 8'd2;
			count_q     <= 5'd1;
			ready_q     <= '0;
			done_q      <= '0;
			started_q   <= '0;
			remnz_q     <= '0;
			time_q      <= '0;
			cur_slot_q  <= IDLE_SLOT;
			slice_q     <= 8'd2;
			head_q      <= '0;
			fcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_POLICY:  policy_q  <= cfg_data[1:0];
					REG_QUANTUM: quantum_q <= cfg_data;
					REG_COUNT:   count_q   <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (cmd.accept_load) begin
				ready_q[in_data.slot]   <= 1'b0;
				started_q[in_data.slot] <= 1'b0;
				done_q[in_data.slot]    <= (in_data.burst_time == '0);
				remnz_q[in_data.slot]   <= (in_data.burst_time != '0);
			end
			if (cmd.scan && arrives) begin
				ready_q[rd_addr] <= 1'b1;
				if (policy_q == POL_RR && push_ok) fcnt_q <= fcnt_q + 1'b1;
			end
			if (cmd.pop) begin
				if (fcnt_q != '0) begin
					head_q <= head_q + 1'b1;
					// A preempted slot re-enters behind, keeping the count.
					if (!(pop_found && !pop_mode_q)) fcnt_q <= fcnt_q - 1'b1;
				end
				if (stat.pop_done) slice_q <= slice_len;
			end
			if (cmd.run) begin
				if (!cur_idle) begin
					started_q[rd_addr] <= 1'b1;
					remnz_q[rd_addr]   <= (new_rem != '0);
					if (policy_q == POL_RR && slice_q != 8'd0) slice_q <= slice_q - 1'b1;
					if (new_rem == '0) begin
						done_q[rd_addr]  <= 1'b1;
						ready_q[rd_addr] <= 1'b0;
						cur_slot_q       <= IDLE_SLOT;
					end else begin
						cur_slot_q <= w_cur_q;
					end
				end else begin
					cur_slot_q <= IDLE_SLOT;
				end
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
				if (tick_q && time_q != TMAX) time_q <= time_q + 1'b1;
			end else begin
				out_valid_q <= out_valid_q && out_stall;
			end
		end
	end

	// Tables, queue storage and working registers.
	always_ff @(posedge clk) begin
		if (cmd.accept_load) begin
			arr_mem[in_data.slot]   <= in_data.arrival_time;
			burst_mem[in_data.slot] <= in_data.burst_time;
			rem_mem[in_data.slot]   <= in_data.burst_time;
			res_q  <= '0;
			tick_q <= 1'b0;
		end
		if (cmd.accept_tick) tick_q <= 1'b1;
		if (cmd.start) begin
			w_cur_q      <= cur_ok ? cur_slot_q : IDLE_SLOT;
			prev_q       <= cur_ok ? cur_slot_q : IDLE_SLOT;
			scan_idx_q   <= '0;
			best_arr_q   <= IDLE_SLOT;
			best_rem_q   <= IDLE_SLOT;
			best_first_q <= IDLE_SLOT;
		end
		if (cmd.scan) begin
			scan_idx_q <= scan_idx_q + 1'b1;
			if (arrives && policy_q == POL_RR && push_ok) fifo_mem[fifo_tail] <= rd_addr;
			if (scan_run) begin
				if (best_arr_q == IDLE_SLOT || rd_arr < best_arr_key_q) begin
					best_arr_q     <= {1'b0, rd_addr};
					best_arr_key_q <= rd_arr;
				end
				if (best_rem_q == IDLE_SLOT || rd_rem < best_rem_key_q) begin
					best_rem_q     <= {1'b0, rd_addr};
					best_rem_key_q <= rd_rem;
				end
				if (best_first_q == IDLE_SLOT) best_first_q <= {1'b0, rd_addr};
			end
		end
		if (cmd.decide) begin
			pop_mode_q <= cur_idle;
			unique case (policy_q)
				POL_FCFS: if (cur_idle) w_cur_q <= best_arr_q;
				POL_SJF:  if (cur_idle) w_cur_q <= best_rem_q;
				POL_SRTF: w_cur_q <= best_rem_q;
				POL_RR:   ;
				default:  ;
			endcase
		end
		if (cmd.pop && stat.pop_done) begin
			if (pop_mode_q) begin
				w_cur_q <= (popped != IDLE_SLOT) ? popped : best_first_q;
			end else if (popped != IDLE_SLOT) begin
				fifo_mem[fifo_tail] <= w_cur_q[SLOT_W-1:0];
				w_cur_q             <= popped;
			end
		end
		if (cmd.run) begin
			res_q <= run_res;
			if (!cur_idle) rem_mem[rd_addr] <= new_rem;
		end
		if (cmd.fin) out_q <= fin_res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	fifo_bound_a: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= MAX_CNT) else $error("ready queue count beyond capacity");

	hold_a: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result changed");

	cur_range_a: assert property (@(posedge clk) disable iff (!arst_n)
		cur_slot_q <= IDLE_SLOT) else $error("current slot out of range");

endmodule

[src/cpu_process_scheduler_top.sv]
// Top level of the tick-driven process scheduler.
//
//  channel | direction | handshake         | beat
//  --------+-----------+-------------------+---------------------------------
//  in      | input     | in_valid/in_stall | cps_in_t: load entry or one tick
//  out     | output    | out_valid/out_stall | cps_out_t: one result per item
//  cfg     | input     | cfg_we            | cfg_index, cfg_data (8 bits)
//
// A load beat goes from idle straight to the finishing step. A tick beat steps through
// start, a scan of the n slots in use, decide, in round robin when the queue is
// consulted a pop step per entry popped or one more when no runnable entry turns up,
// then run and finish: the table is scanned one slot a cycle through a single read port.
// Reset clears the process flags, time and the queue pointers at once; no clearing pass.
// A result that waits in the output register stalls the input until it is taken.
module cpu_process_scheduler_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cps_pkg::cps_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output cps_pkg::cps_out_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);
	import cps_pkg::*;

	cps_cmd_t  cmd;
	cps_stat_t stat;

	// The controller only sequences; all state of the scheduler sits in the datapath.
	cps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	cps_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// A new result appears only from the finishing step of the sequence.
	rise_a: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.fin)) else $error("result without finish step");

	// An accepted beat always finds the output register free afterward.
	accept_a: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !out_valid) else $error("output overrun");

	// Completion and first dispatch only ever describe a running process.
	busy_a: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.completed || out_data.first_run || out_data.dispatched))
		|-> out_data.busy_res) else $error("metric without running process");

endmodule

[sim/tb_cpu_process_scheduler_top.sv]
// Testbench for the tick-driven process scheduler: random job sets under every policy.
`timescale 1ns / 1ps

module tb_cpu_process_scheduler_top;
	import cps_pkg::*;

	localparam int NPROC       = 16;
	localparam int ITEM_TARGET = 1550;
	localparam int QUIET_FROM  = 1350;
	// Margin for the slowest tick: a scan of all 16 slots, the other steps and a full queue.
	localparam int DRAIN_WAIT  = 48;
	localparam int CYCLE_LIMIT = 600000;

	// The scoreboard carries its own copy of the scheduler state and
	// configuration, and keeps the results that accepted beats will produce.
	class sched_scoreboard;
		logic [1:0]  policy = POL_FCFS;
		logic [7:0]  quantum = 8'd2;
		logic [4:0]  count = 5'd1;
		logic [15:0] arr [NPROC];
		logic [15:0] bur [NPROC];
		logic [15:0] rem [NPROC];
		bit          rdy [NPROC];
		bit          dn [NPROC];
		bit          st [NPROC];
		logic [15:0] tnow = '0;
		int          cur = NPROC;
		int          slice = 2;
		int          fifo [NPROC];
		int          head = 0;
		int          fcnt = 0;
		cps_out_t    results_due [$];
		int          errors = 0;

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void write_reg(logic [1:0] idx, logic [7:0] v);
			case (idx)
				REG_POLICY:  policy = v[1:0];
				REG_QUANTUM: quantum = v;
				REG_COUNT:   count = v[4:0];
				default: ;
			endcase
		endfunction

		function int slots_used();
			return (count > NPROC) ? NPROC : int'(count);
		endfunction

		function bit runnable(int s, int n);
			return s < n && rdy[s] && !dn[s];
		endfunction

		function void push(int s);
			if (fcnt < NPROC) begin
				fifo[(head + fcnt) % NPROC] = s;
				fcnt++;
			end
		endfunction

		function int pop(int n);
			int s;
			while (fcnt > 0) begin
				s = fifo[head];
				head = (head + 1) % NPROC;
				fcnt--;
				if (runnable(s, n))
					return s;
			end
			return NPROC;
		endfunction

		// Key 0 picks by remaining work, 1 by arrival, 2 takes the first ready slot.
		function int pick(int n, int key);
			int best;
			logic [15:0] bk, k;
			best = NPROC;
			bk = '0;
			for (int i = 0; i < n; i++) begin
				if (!runnable(i, n))
					continue;
				k = (key == 0) ? rem[i] : ((key == 1) ? arr[i] : 16'd0);
				if (best == NPROC || k < bk) begin
					best = i;
					bk = k;
				end
			end
			return best;
		endfunction

		function void note_input(cps_in_t it);
			cps_out_t r;
			int n, c, p, s;
			logic [15:0] t, fin, tat;
			r = '0;
			n = slots_used();
			t = tnow;
			if (it.opcode == OP_LOAD) begin
				arr[it.slot] = it.arrival_time;
				bur[it.slot] = it.burst_time;
				rem[it.slot] = it.burst_time;
				rdy[it.slot] = 0;
				st[it.slot] = 0;
				dn[it.slot] = (it.burst_time == 0);
			end else begin
				c = cur;
				if (c >= NPROC || !runnable(c, n))
					c = NPROC;
				p = c;
				for (int i = 0; i < n; i++) begin
					if (arr[i] == t && !rdy[i] && !dn[i]) begin
						rdy[i] = 1;
						if (policy == POL_RR)
							push(i);
					end
				end
				case (policy)
					POL_FCFS: if (c == NPROC) c = pick(n, 1);
					POL_SJF:  if (c == NPROC) c = pick(n, 0);
					POL_SRTF: c = pick(n, 0);
					default: begin
						if (c == NPROC) begin
							c = pop(n);
							if (c == NPROC)
								c = pick(n, 2);
							slice = (quantum == 0) ? 1 : int'(quantum);
						end else if (slice == 0) begin
							s = pop(n);
							if (s != NPROC) begin
								push(c);
								c = s;
							end
							slice = (quantum == 0) ? 1 : int'(quantum);
						end
					end
				endcase
				if (c != NPROC) begin
					r.busy_res = 1;
					r.running_slot = c[3:0];
					r.dispatched = (c != p);
					if (!st[c]) begin
						st[c] = 1;
						r.first_run = 1;
						r.response_time = (t >= arr[c]) ? t - arr[c] : 16'd0;
					end
					rem[c] = rem[c] - 1;
					if (policy == POL_RR && slice > 0)
						slice--;
					if (rem[c] == 0) begin
						fin = (t != 16'hFFFF) ? t + 1 : t;
						dn[c] = 1;
						rdy[c] = 0;
						tat = (fin >= arr[c]) ? fin - arr[c] : 16'd0;
						r.completed = 1;
						r.turnaround_time = tat;
						r.waiting_time = (tat > bur[c]) ? tat - bur[c] : 16'd0;
						c = NPROC;
					end
				end
				cur = c;
			end
			r.all_done = 1;
			for (int i = 0; i < n; i++)
				if (rem[i] != 0)
					r.all_done = 0;
			r.current_tick = t;
			if (it.opcode == OP_TICK && tnow != 16'hFFFF)
				tnow++;
			results_due.push_back(r);
		endfunction

		task cmp(string nm, longint got, longint want);
			if (got != want)
				report($sformatf("%s got %0d expected %0d", nm, got, want));
		endtask

		task check(cps_out_t got);
			cps_out_t e;
			if (results_due.size() == 0) begin
				report("result beat with nothing outstanding");
				return;
			end
			e = results_due.pop_front();
			cmp("busy_res", got.busy_res, e.busy_res);
			cmp("running_slot", got.running_slot, e.running_slot);
			cmp("dispatched", got.dispatched, e.dispatched);
			cmp("first_run", got.first_run, e.first_run);
			cmp("response_time", got.response_time, e.response_time);
			cmp("completed", got.completed, e.completed);
			cmp("turnaround_time", got.turnaround_time, e.turnaround_time);
			cmp("waiting_time", got.waiting_time, e.waiting_time);
			cmp("all_done", got.all_done, e.all_done);
			cmp("current_tick", got.current_tick, e.current_tick);
		endtask
	endclass

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_stall;
	cps_in_t    in_data = '0;
	logic       out_valid;
	logic       out_stall = 0;
	cps_out_t   out_data;
	logic       cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	sched_scoreboard sched_sb = new;
	int  items_sent = 0;
	int  cycles = 0;
	bit  quiet = 0;
	int  stall_left = 0;

	cpu_process_scheduler_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: stall in random bursts; no new burst starts in the quiet tail.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1;
			stall_left--;
		end else if (!quiet && $urandom_range(5) == 0) begin
			out_stall <= 1;
			stall_left = $urandom_range(3);
		end else begin
			out_stall <= 0;
		end
	end

	// Every result beat is checked against the oldest outstanding prediction.
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sched_sb.check(out_data);

	// Present one beat and hold it until the block takes it. The valid line is
	// left high, except for a random gap now and then, so that a following beat can go straight out.
	task automatic send_beat(cps_in_t it);
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sched_sb.note_input(it);
		items_sent++;
		if (!quiet && $urandom_range(4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_load(int s, int at, int bt);
		cps_in_t it;
		it.opcode = OP_LOAD;
		it.slot = s[3:0];
		it.arrival_time = at[15:0];
		it.burst_time = bt[15:0];
		send_beat(it);
	endtask

	task automatic send_tick();
		cps_in_t it;
		logic [63:0] rnd;
		rnd = {$urandom, $urandom};
		it = rnd[$bits(cps_in_t)-1:0];
		it.opcode = OP_TICK;
		send_beat(it);
	endtask

	// Registers change only once the block has gone quiet.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sched_sb.results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		sched_sb.write_reg(idx, v);
	endtask

	// One job set: fresh settings, a table loaded in arrival order, then ticks
	// until it should be done, with stray reloads mixed in now and then.
	task automatic run_job_set();
		int n, at, span, nticks, q, pc;
		drain();
		q = $urandom_range(9);
		q = (q == 0) ? 0 : ((q == 1) ? 255 : $urandom_range(1, 4));
		pc = $urandom_range(11);
		pc = (pc == 0) ? 0 : ((pc == 1) ? $urandom_range(17, 31) : $urandom_range(1, 16));
		write_reg(REG_POLICY, 8'($urandom_range(3)));
		write_reg(REG_QUANTUM, 8'(q));
		write_reg(REG_COUNT, 8'(pc));
		n = sched_sb.slots_used();
		span = 4;
		// Now and then the old table is kept so leftovers meet the new policy.
		if ($urandom_range(4) != 0) begin
			at = sched_sb.tnow + $urandom_range(2);
			for (int i = 0; i < n; i++) begin
				send_load(i, at, ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6));
				span += 6;
				at += $urandom_range(3);
			end
			span += at - sched_sb.tnow;
		end
		nticks = span + $urandom_range(4);
		for (int k = 0; k < nticks && items_sent < ITEM_TARGET; k++) begin
			if ($urandom_range(14) == 0)
				send_load($urandom_range(15), $urandom_range(1) ? $urandom :
					sched_sb.tnow + $urandom_range(3), $urandom_range(1) ? $urandom :
					$urandom_range(1, 4));
			send_tick();
			quiet = (items_sent >= QUIET_FROM);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: every slot loaded first, slot 0 before anything reads it,
		// with field extremes and a zero burst among them.
		send_load(0, 0, 1);
		send_load(1, 16'hFFFF, 16'hFFFF);
		send_load(2, 0, 0);
		send_load(3, 16'hFFFF, 1);
		send_load(4, 0, 16'hFFFF);
		for (int i = 5; i < NPROC; i++)
			send_load(i, 16'h5555 << (i % 2), 16'hAAAA >> (i % 2));
		repeat (3) send_tick();
		// Two processes arriving together with equal work: the tie goes low.
		drain();
		write_reg(REG_POLICY, {6'd0, POL_SRTF});
		write_reg(REG_COUNT, 8'd2);
		send_load(0, sched_sb.tnow, 2);
		send_load(1, sched_sb.tnow, 2);
		repeat (5) send_tick();

		while (items_sent < ITEM_TARGET)
			run_job_set();

		drain();
		if (sched_sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
src/cps_pkg.sv
src/cps_ctrl.sv
src/cps_datapath.sv
src/cpu_process_scheduler_top.sv
sim/tb_cpu_process_scheduler_top.sv
